>>> sv/dsge_pkg.sv
`default_nettype none
package dsge_pkg;

    localparam int SOBEL_W = 10;
    localparam int GRAD_W  = 9;
    localparam int ROWC_W  = 16;
    localparam int COLC_W  = 11;
    localparam int CFG_W   = 16;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel;
    } in_word_t;

    typedef struct packed {
        logic [SOBEL_W-1:0] sobel_right;
        logic [SOBEL_W-1:0] sobel_left;
        logic [GRAD_W-1:0]  gradient;
        logic               frame_last;
    } out_word_t;

endpackage
`default_nettype wire

>>> sv/dsge_ram.sv
`default_nettype none
module dsge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/dsge_isqrt.sv
`default_nettype none
module dsge_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] radicand,
    output logic             done,
    output logic [8:0]       root
);
    // Restoring square root, one result bit per cycle.
    logic [17:0] rem_reg, rem_next;
    logic [8:0]  res_reg, res_next;
    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [17:0] src_reg, src_next;
    logic [17:0] trial;
    logic [17:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        src_next  = src_reg;
        shifted   = {rem_reg[15:0], src_reg[17:16]};
        trial     = {7'd0, res_reg, 2'b01};
        done      = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            res_next  = '0;
            step_next = 4'd9;
            busy_next = 1'b1;
            src_next  = {1'b0, radicand};
        end
        else if (busy_reg)
        begin
            src_next = {src_reg[15:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next = shifted - trial;
                res_next = {res_reg[7:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                res_next = {res_reg[7:0], 1'b0};
            end
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign root = res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        src_reg <= src_next;
    end
endmodule
`default_nettype wire

>>> sv/diagonal_sobel_gradient_edge.sv
`default_nettype none
// Each accepted word first reads the line stores, then each result it causes passes
// the CALC state, the bit-serial square root (one root bit a cycle) and the output
// register. A word yields zero, one or two results; input stalls until it is done.
// Results appear one row and one column after their pixel.
// Reset clears counters, window, state and output valid; line stores and data registers are not cleared.
module diagonal_sobel_gradient_edge #(
    parameter int MAX_COLS = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire dsge_pkg::in_word_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output dsge_pkg::out_word_t       out_data,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import dsge_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam int CW = AW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ROWC_W-1:0] rows_cfg_reg;
    logic [COLC_W-1:0] cols_cfg_reg;
    logic [ROWC_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0]     col_cnt_reg, col_cnt_next;
    logic [CW-1:0]     drain_cnt_reg, drain_cnt_next;
    logic [7:0]        win_reg [9];
    logic              drain_reg;
    logic [7:0]        bot_in_reg;
    logic [AW-1:0]     j_reg;
    logic              first_row_reg;
    logic              row_end_reg;
    logic              pend_a_reg, pend_a_next;
    logic              pend_b_reg, pend_b_next;
    logic [1:0]        lc_reg, lc_next;
    logic [1:0]        cc_reg, cc_next;
    logic              last_sel_reg, last_sel_next;
    logic [SOBEL_W-1:0] sr_reg, sl_reg;
    logic              last_reg;
    out_word_t         out_reg;
    logic              out_valid_reg;

    logic [ROWC_W-1:0] rows_eff;
    logic [CW-1:0]     cols_eff;
    logic [CW-1:0]     j_full;
    logic [AW-1:0]     j_idx;
    logic              accept, drop, active;
    logic [7:0]        old_rd, new_rd;

    assign rows_eff = (rows_cfg_reg == '0) ? ROWC_W'(1) : rows_cfg_reg;
    always_comb
    begin
        cols_eff = (cols_cfg_reg == '0) ? CW'(1) : CW'(cols_cfg_reg);
        if (32'(cols_cfg_reg) > MAX_COLS)
        begin
            cols_eff = CW'(MAX_COLS);
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign drop     = (in_data.action == ACT_DRAIN) ? (row_cnt_reg < rows_eff)
                                                    : (row_cnt_reg >= rows_eff);
    assign active   = accept && !drop;
    always_comb
    begin
        j_full = (in_data.action == ACT_DRAIN) ? drain_cnt_reg : col_cnt_reg;
        if (32'(j_full) >= MAX_COLS)
        begin
            j_full = CW'(MAX_COLS - 1);
        end
    end
    assign j_idx = j_full[AW-1:0];

    logic [7:0] mid_v, top_v, bot_v;
    assign mid_v = new_rd;
    assign bot_v = drain_reg ? mid_v : bot_in_reg;
    assign top_v = first_row_reg ? mid_v : old_rd;

    logic wr_en;
    assign wr_en = (state_reg == ST_READ) && !drain_reg;

    dsge_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_older (
        .clk(clk), .we(wr_en), .waddr(j_reg), .wdata(mid_v),
        .raddr(j_idx), .rdata(old_rd)
    );
    dsge_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_newer (
        .clk(clk), .we(wr_en), .waddr(j_reg), .wdata(bot_v),
        .raddr(j_idx), .rdata(new_rd)
    );

    // Window evaluation for the selected column slots.
    logic signed [11:0] tl, tc, tr, ml, mc, mr, bl, bc, br;
    logic signed [11:0] right_s, left_s, dd, dr;
    logic [11:0]        right_a, left_a;
    logic [7:0]         dd_a, dr_a;
    logic [16:0]        radicand;
    logic               root_start, root_done;
    logic [8:0]         root;

    always_comb
    begin
        tl = 12'(win_reg[lc_reg]);
        tc = 12'(win_reg[cc_reg]);
        tr = 12'(win_reg[2]);
        ml = 12'(win_reg[3 + lc_reg]);
        mc = 12'(win_reg[3 + cc_reg]);
        mr = 12'(win_reg[5]);
        bl = 12'(win_reg[6 + lc_reg]);
        bc = 12'(win_reg[6 + cc_reg]);
        br = 12'(win_reg[8]);
        right_s = 12'(2 * tl) + tc + ml - mr - bc - 12'(2 * br);
        left_s  = tc + 12'(2 * tr) - ml + mr - 12'(2 * bl) - bc;
        dd = mc - bc;
        dr = mc - mr;
        right_a = right_s[11] ? -right_s : right_s;
        left_a  = left_s[11] ? -left_s : left_s;
        dd_a = dd[11] ? 8'(-dd) : 8'(dd);
        dr_a = dr[11] ? 8'(-dr) : 8'(dr);
        radicand = 17'(dd_a) * 17'(dd_a) + 17'(dr_a) * 17'(dr_a);
    end

    assign root_start = (state_reg == ST_CALC);

    dsge_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(root_start), .radicand(radicand),
        .done(root_done), .root(root)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        pend_a_next    = pend_a_reg;
        pend_b_next    = pend_b_reg;
        lc_next        = lc_reg;
        cc_next        = cc_reg;
        last_sel_next  = last_sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (active)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                pend_a_next = (drain_reg || row_cnt_reg >= ROWC_W'(1)) && (j_reg != '0);
                pend_b_next = (drain_reg || row_cnt_reg >= ROWC_W'(1)) && row_end_reg;
                if (drain_reg)
                begin
                    if (row_end_reg)
                    begin
                        drain_cnt_next = '0;
                        col_cnt_next   = '0;
                        row_cnt_next   = '0;
                    end
                    else
                    begin
                        drain_cnt_next = CW'(j_reg) + CW'(1);
                    end
                end
                else if (row_end_reg)
                begin
                    col_cnt_next = '0;
                    row_cnt_next = row_cnt_reg + ROWC_W'(1);
                end
                else
                begin
                    col_cnt_next = CW'(j_reg) + CW'(1);
                end
                state_next = ST_CALC;
                if (!((drain_reg || row_cnt_reg >= ROWC_W'(1))
                      && (j_reg != '0 || row_end_reg)))
                begin
                    state_next = ST_IDLE;
                end
                else if ((drain_reg || row_cnt_reg >= ROWC_W'(1)) && j_reg != '0)
                begin
                    lc_next = (j_reg == AW'(1)) ? 2'd1 : 2'd0;
                    cc_next = 2'd1;
                    last_sel_next = 1'b0;
                end
                else
                begin
                    lc_next = (j_reg == '0) ? 2'd2 : 2'd1;
                    cc_next = 2'd2;
                    last_sel_next = drain_reg;
                end
            end
            ST_CALC:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    if (pend_a_reg)
                    begin
                        pend_a_next = 1'b0;
                    end
                    else
                    begin
                        pend_b_next = 1'b0;
                    end
                    if (pend_a_reg && pend_b_reg)
                    begin
                        lc_next = (j_reg == '0) ? 2'd2 : 2'd1;
                        cc_next = 2'd2;
                        last_sel_next = drain_reg;
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_cfg_reg  <= ROWC_W'(1);
            cols_cfg_reg  <= COLC_W'(1);
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            drain_cnt_reg <= '0;
            pend_a_reg    <= 1'b0;
            pend_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            pend_a_reg    <= pend_a_next;
            pend_b_reg    <= pend_b_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROW_COUNT: rows_cfg_reg <= cfg_data[ROWC_W-1:0];
                    CFG_COL_COUNT: cols_cfg_reg <= cfg_data[COLC_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_READ)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]     <= win_reg[k*3 + 1];
                    win_reg[k*3 + 1] <= win_reg[k*3 + 2];
                end
                win_reg[2] <= top_v;
                win_reg[5] <= mid_v;
                win_reg[8] <= bot_v;
            end
            if (state_reg == ST_OUT && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lc_reg       <= lc_next;
        cc_reg       <= cc_next;
        last_sel_reg <= last_sel_next;
        if (active)
        begin
            drain_reg     <= in_data.action;
            bot_in_reg    <= in_data.pixel;
            j_reg         <= j_idx;
            first_row_reg <= (in_data.action == ACT_DRAIN) ? (rows_eff == ROWC_W'(1))
                                                           : (row_cnt_reg == ROWC_W'(1));
            row_end_reg   <= (j_full + CW'(1) >= cols_eff);
        end
        if (state_reg == ST_CALC)
        begin
            sr_reg   <= (right_a > 12'd1023) ? 10'd1023 : right_a[9:0];
            sl_reg   <= (left_a > 12'd1023) ? 10'd1023 : left_a[9:0];
            last_reg <= last_sel_reg;
        end
        if (state_reg == ST_OUT && !out_valid_reg)
        begin
            out_reg.sobel_right <= sr_reg;
            out_reg.sobel_left  <= sl_reg;
            out_reg.gradient    <= root;
            out_reg.frame_last  <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result word changed while stalled");

    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        active |=> in_stall;
    endproperty
    a_busy: assert property (p_busy_after_accept) else $error("block not busy after accept");

    property p_col_bound;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (32'(col_cnt_reg) <= MAX_COLS);
    endproperty
    a_col_bound: assert property (p_col_bound) else $error("column counter out of range");
endmodule
`default_nettype wire
